// ===== design/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timeout queue
// Field structs, request codes, status codes, the sequencer states and a saturating subtract.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned TimerSlots   = 16;
  localparam int unsigned RunningDepth = 4;
  localparam int unsigned SlotIdxW     = $clog2(TimerSlots);
  localparam int unsigned SlotCntW     = $clog2(TimerSlots + 1);
  localparam int unsigned RunIdxW      = (RunningDepth > 1) ? $clog2(RunningDepth) : 1;
  localparam int unsigned RunCntW      = $clog2(RunningDepth + 1);
  localparam int unsigned RemW         = 40;

  localparam logic signed [RemW-1:0] RemMax = {1'b0, {(RemW-1){1'b1}}};
  localparam logic signed [RemW-1:0] RemMin = {1'b1, {(RemW-1){1'b0}}};

  localparam logic [19:0] MinRepeatReset = 20'd1000;
  localparam logic [1:0]  RegMinRepeat   = 2'd0;

  typedef enum logic [3:0] {
    FuncAdd     = 4'd0,
    FuncRepeat  = 4'd1,
    FuncRemAll  = 4'd2,
    FuncRemNext = 4'd3,
    FuncQuery   = 4'd4,
    FuncElapse  = 4'd5,
    FuncService = 4'd6,
    FuncNextExp = 4'd7,
    FuncRelease = 4'd8,
    FuncWait    = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatNone     = 2'd2,
    StatRunFull  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StElapse,
    StScan,
    StShift,
    StDone
  } state_e;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] handler_id;
    logic [31:0] user_id;
    logic [31:0] delay_us;
    logic [31:0] elapsed_us;
    logic [31:0] wait_limit_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  match_count;
    logic [15:0] out_handler;
    logic [31:0] out_user;
    logic [31:0] wait_us;
  } out_item_t;

  typedef struct packed {
    logic [15:0]            handler;
    logic [31:0]            user;
    logic signed [RemW-1:0] remaining;
    logic                   skip;
  } entry_t;

  // Subtract with saturation at the signed minimum.
  function automatic logic signed [RemW-1:0] sat_sub(logic signed [RemW-1:0] v,
                                                     logic [31:0] e);
    logic signed [RemW:0] r;
    r = {v[RemW-1], v} - $signed({{(RemW-31){1'b0}}, e});
    if (r < $signed({RemMin[RemW-1], RemMin})) return RemMin;
    return r[RemW-1:0];
  endfunction

endpackage

// ===== design/stq_slots.sv =====
// ----------------------------------------------------------------------------
// stq_slots: timer slot array
// Holds the sorted entries; one slot can be read and one written per cycle.
// ----------------------------------------------------------------------------
module stq_slots (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [stq_pkg::SlotIdxW-1:0]      waddr_i,
  input  stq_pkg::entry_t                   wdata_i,
  input  logic [stq_pkg::SlotIdxW-1:0]      raddr_i,
  output stq_pkg::entry_t                   rdata_o
);

  stq_pkg::entry_t mem_q [stq_pkg::TimerSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Combinational read of a 16-entry register file; all reads come from one
  // address so a single read mux serves the whole sequencer.
  assign rdata_o = mem_q[raddr_i];

endmodule

// ===== design/sorted_timeout_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timeout_queue: sorted one-shot timer queue
// Sequencer around a slot array, running stack and one config register.
// ----------------------------------------------------------------------------
// Each request first makes one pass over the queued slots, one slot per cycle,
// to apply the elapsed time. It then makes a search pass, except for release,
// unknown codes and requests that end early on an empty or full queue. Add and
// repeat follow with a shift pass that moves slots one at a time to open a gap;
// remove next and next expired do so to close a gap when an entry was found.
// The single slot read port sets the pace. The block does not accept a new beat
// until the result beat has been taken.
module sorted_timeout_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  stq_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output stq_pkg::out_item_t    out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned SIW = stq_pkg::SlotIdxW;
  localparam int unsigned SCW = stq_pkg::SlotCntW;
  localparam int unsigned RW  = stq_pkg::RemW;

  stq_pkg::state_e state_q, state_d;
  stq_pkg::in_item_t req_q, req_d;
  stq_pkg::out_item_t res_q, res_d;
  logic [19:0] min_rep_q;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [stq_pkg::RunCntW-1:0] rdep_q, rdep_d;
  logic [SCW-1:0] idx_q, idx_d;
  logic [SCW-1:0] pos_q, pos_d;
  logic found_q, found_d;
  logic [5:0] mcnt_q, mcnt_d;
  logic ins_q, ins_d;
  stq_pkg::entry_t carry_q, carry_d;
  logic signed [RW-1:0] t_q, t_d;

  stq_pkg::entry_t run_q [stq_pkg::RunningDepth];
  logic run_we;
  stq_pkg::entry_t run_wd;

  logic we;
  logic [SIW-1:0] waddr, raddr;
  stq_pkg::entry_t wdata, rd;

  stq_slots u_slots (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == {stq_pkg::RegMinRepeat}) ? {12'd0, min_rep_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rep_q <= stq_pkg::MinRepeatReset;
    end else if (psel && penable && pwrite && (paddr == stq_pkg::RegMinRepeat)) begin
      min_rep_q <= pwdata[19:0];
    end
  end

  assign in_stall_o  = (state_q != stq_pkg::StIdle);
  assign out_valid_o = (state_q == stq_pkg::StDone);
  assign out_data_o  = res_q;

  logic [stq_pkg::RunIdxW-1:0] top_idx;
  assign top_idx = stq_pkg::RunIdxW'(rdep_q - 1'b1);

  logic match_w, match_x;
  assign match_w = (rd.handler == req_q.handler_id) &&
                   ((rd.user == req_q.user_id) || (req_q.user_id == 32'd0));
  assign match_x = (rd.handler == req_q.handler_id) && (rd.user == req_q.user_id);

  always_comb begin
    logic signed [RW+1:0] sum;
    state_d = state_q;
    req_d   = req_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    rdep_d  = rdep_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    found_d = found_q;
    mcnt_d  = mcnt_q;
    ins_d   = ins_q;
    carry_d = carry_q;
    t_d     = t_q;
    we      = 1'b0;
    waddr   = idx_q[SIW-1:0];
    wdata   = rd;
    raddr   = idx_q[SIW-1:0];
    run_we  = 1'b0;
    run_wd  = rd;
    sum     = '0;
    unique case (state_q)
      stq_pkg::StIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          res_d   = '0;
          idx_d   = '0;
          found_d = 1'b0;
          mcnt_d  = '0;
          ins_d   = 1'b0;
          state_d = stq_pkg::StElapse;
        end
      end
      stq_pkg::StElapse: begin
        if (idx_q < cnt_q) begin
          we = 1'b1;
          wdata = rd;
          wdata.remaining = stq_pkg::sat_sub(rd.remaining, req_q.elapsed_us);
          idx_d = idx_q + 1'b1;
        end else begin
          idx_d = '0;
          pos_d = cnt_q;
          state_d = stq_pkg::StScan;
          // Running stack is small; all levels age together.
          t_d = signed'({8'd0, req_q.delay_us});
          if (req_q.func == stq_pkg::FuncRepeat && rdep_q != '0) begin
            sum = $signed({{2{run_q[top_idx].remaining[RW-1]}}, run_q[top_idx].remaining})
                - $signed({{(RW-30){1'b0}}, req_q.elapsed_us})
                + $signed({{(RW-30){1'b0}}, req_q.delay_us});
            // Stack entry aged by elapsed; clamp aged value first.
            if ($signed({{2{run_q[top_idx].remaining[RW-1]}}, run_q[top_idx].remaining})
                - $signed({{(RW-30){1'b0}}, req_q.elapsed_us})
                < $signed({{2{stq_pkg::RemMin[RW-1]}}, stq_pkg::RemMin})) begin
              sum = $signed({{2{stq_pkg::RemMin[RW-1]}}, stq_pkg::RemMin})
                  + $signed({{(RW-30){1'b0}}, req_q.delay_us});
            end
            if (sum < 0) t_d = signed'({20'd0, min_rep_q});
            else if (sum > $signed({2'b00, stq_pkg::RemMax})) t_d = stq_pkg::RemMax;
            else t_d = sum[RW-1:0];
          end
          unique case (req_q.func)
            stq_pkg::FuncAdd, stq_pkg::FuncRepeat: begin
              if (cnt_q >= SCW'(stq_pkg::TimerSlots)) begin
                res_d.status = stq_pkg::StatFull;
                state_d = stq_pkg::StDone;
              end
            end
            stq_pkg::FuncRelease: begin
              if (rdep_q == '0) res_d.status = stq_pkg::StatNone;
              else begin
                rdep_d = rdep_q - 1'b1;
                res_d.out_handler = run_q[top_idx].handler;
                res_d.out_user = run_q[top_idx].user;
              end
              state_d = stq_pkg::StDone;
            end
            stq_pkg::FuncWait: begin
              if (cnt_q == '0) begin
                res_d.status = stq_pkg::StatNone;
                res_d.wait_us = req_q.wait_limit_us;
                state_d = stq_pkg::StDone;
              end
            end
            stq_pkg::FuncNextExp: begin
              if (cnt_q == '0) begin
                res_d.status = stq_pkg::StatNone;
                state_d = stq_pkg::StDone;
              end
            end
            stq_pkg::FuncRemAll, stq_pkg::FuncRemNext, stq_pkg::FuncQuery,
            stq_pkg::FuncService: ;
            default: state_d = stq_pkg::StDone;
          endcase
        end
      end
      stq_pkg::StScan: begin
        raddr = idx_q[SIW-1:0];
        if (idx_q >= cnt_q) begin
          // End of the pass: decide.
          idx_d = pos_q;
          unique case (req_q.func)
            stq_pkg::FuncAdd, stq_pkg::FuncRepeat: begin
              carry_d = '{handler: req_q.handler_id, user: req_q.user_id,
                          remaining: t_q, skip: 1'b1};
              ins_d = 1'b1;
              state_d = stq_pkg::StShift;
            end
            stq_pkg::FuncRemAll: begin
              res_d.status = (mcnt_q != '0) ? stq_pkg::StatOk : stq_pkg::StatNone;
              res_d.match_count = (mcnt_q > 6'd31) ? 5'd31 : mcnt_q[4:0];
              cnt_d = cnt_q - SCW'(mcnt_q);
              state_d = stq_pkg::StDone;
            end
            stq_pkg::FuncRemNext, stq_pkg::FuncNextExp: begin
              res_d.match_count = (req_q.func == stq_pkg::FuncRemNext) ?
                                  ((mcnt_q > 6'd31) ? 5'd31 : mcnt_q[4:0]) : 5'd0;
              if (found_q) state_d = stq_pkg::StShift;
              else begin
                res_d.status = stq_pkg::StatNone;
                state_d = stq_pkg::StDone;
              end
            end
            stq_pkg::FuncQuery: begin
              res_d.status = (mcnt_q != '0) ? stq_pkg::StatOk : stq_pkg::StatNone;
              res_d.match_count = (mcnt_q > 6'd31) ? 5'd31 : mcnt_q[4:0];
              state_d = stq_pkg::StDone;
            end
            default: state_d = stq_pkg::StDone;
          endcase
        end else begin
          idx_d = idx_q + 1'b1;
          case (req_q.func)
            stq_pkg::FuncAdd, stq_pkg::FuncRepeat: begin
              if (!found_q && rd.remaining > t_q) begin
                found_d = 1'b1;
                pos_d = idx_q;
                idx_d = cnt_q;
              end
            end
            stq_pkg::FuncRemAll: begin
              // Compact in place: survivors move down by the match count.
              if (match_w) mcnt_d = mcnt_q + 1'b1;
              else begin
                we = 1'b1;
                waddr = SIW'(idx_q - SCW'(mcnt_q));
                wdata = rd;
              end
            end
            stq_pkg::FuncRemNext: begin
              if (match_w) begin
                mcnt_d = mcnt_q + 1'b1;
                if (!found_q) begin
                  found_d = 1'b1;
                  pos_d = idx_q;
                  res_d.out_handler = rd.handler;
                  res_d.out_user = rd.user;
                end
              end
            end
            stq_pkg::FuncQuery: if (match_x) mcnt_d = mcnt_q + 1'b1;
            stq_pkg::FuncService: begin
              we = 1'b1;
              wdata = rd;
              wdata.skip = 1'b0;
            end
            stq_pkg::FuncNextExp: begin
              idx_d = cnt_q;
              if (idx_q == '0 && rd.remaining > 0) begin
                // Head not yet due.
              end else if (!rd.skip) begin
                if (rd.remaining <= 0) begin
                  if (rdep_q >= stq_pkg::RunCntW'(stq_pkg::RunningDepth)) begin
                    res_d.status = stq_pkg::StatRunFull;
                  end else begin
                    found_d = 1'b1;
                    pos_d = idx_q;
                    run_we = 1'b1;
                    run_wd = rd;
                    rdep_d = rdep_q + 1'b1;
                    res_d.out_handler = rd.handler;
                    res_d.out_user = rd.user;
                  end
                end
              end else begin
                idx_d = idx_q + 1'b1;
              end
              if (idx_q == '0 && rd.remaining > 0) begin
                res_d.status = stq_pkg::StatNone;
                state_d = stq_pkg::StDone;
              end else if (!rd.skip && rd.remaining <= 0 &&
                           rdep_q >= stq_pkg::RunCntW'(stq_pkg::RunningDepth)) begin
                state_d = stq_pkg::StDone;
              end
            end
            stq_pkg::FuncWait: begin
              if (rd.remaining < 0) res_d.wait_us = '0;
              else if (rd.remaining < signed'({8'd0, req_q.wait_limit_us}))
                res_d.wait_us = rd.remaining[31:0];
              else res_d.wait_us = req_q.wait_limit_us;
              state_d = stq_pkg::StDone;
            end
            default: ;
          endcase
        end
      end
      stq_pkg::StShift: begin
        if (ins_q) begin
          // Ripple toward the tail: store carry, pick up the displaced slot.
          raddr = idx_q[SIW-1:0];
          we = 1'b1;
          waddr = idx_q[SIW-1:0];
          wdata = carry_q;
          carry_d = rd;
          idx_d = idx_q + 1'b1;
          if (idx_q == cnt_q) begin
            cnt_d = cnt_q + 1'b1;
            state_d = stq_pkg::StDone;
          end
        end else begin
          // Close the gap left by a removed entry.
          if (idx_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1;
            state_d = stq_pkg::StDone;
          end else begin
            raddr = SIW'(idx_q + 1'b1);
            we = 1'b1;
            waddr = idx_q[SIW-1:0];
            wdata = rd;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      stq_pkg::StDone: begin
        if (!out_stall_i) state_d = stq_pkg::StIdle;
      end
      default: state_d = stq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::StIdle;
      cnt_q   <= '0;
      rdep_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rdep_q  <= rdep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    mcnt_q  <= mcnt_d;
    ins_q   <= ins_d;
    carry_q <= carry_d;
    t_q     <= t_d;
  end

  // Running stack: ages with the elapse pass, pushed by next expired.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < stq_pkg::RunningDepth; k++) begin
      if (state_q == stq_pkg::StElapse && idx_q >= cnt_q) begin
        run_q[k].remaining <= stq_pkg::sat_sub(run_q[k].remaining, req_q.elapsed_us);
      end
    end
    if (run_we) begin
      run_q[rdep_q[stq_pkg::RunIdxW-1:0]] <= run_wd;
    end
  end

endmodule
